@@ hdl/sha256_pkg.sv @@
// SHA-256 package: round constants, initial hash, sequencer state type.
// No dependencies.
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Controls from the sequencer to the round unit.
  typedef struct packed {
    logic       load;   // copy chain into working vars
    logic       round;  // one round step
    logic       fold;   // add working vars into chain
    logic       init;   // chain back to initial hash
    logic [5:0] rnd;    // round index
  } rnd_ctl_t;

endpackage

@@ hdl/sha256_round.sv @@
// SHA-256 round unit: chain value, working variables, message schedule window.
// Depends on sha256_pkg.
module sha256_round (
  input  logic                 clk,
  input  sha256_pkg::rnd_ctl_t ctl,
  input  logic [31:0]          w_in,     // block word for rounds 0..15
  input  logic                 rst,
  input  logic [2:0]           rd_idx,
  output logic [31:0]          rd_word
);

  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [31:0] wt, s0, s1, t1, t2, ch, mj, e0, e1;

  always_comb begin
    s0 = sha256_pkg::rotr(w[1], 7) ^ sha256_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = sha256_pkg::rotr(w[14], 17) ^ sha256_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    wt = (ctl.rnd < 6'd16) ? w_in : (s1 + w[9] + s0 + w[0]);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    e1 = sha256_pkg::rotr(v[4], 6) ^ sha256_pkg::rotr(v[4], 11) ^ sha256_pkg::rotr(v[4], 25);
    e0 = sha256_pkg::rotr(v[0], 2) ^ sha256_pkg::rotr(v[0], 13) ^ sha256_pkg::rotr(v[0], 22);
    t1 = v[7] + e1 + ch + sha256_pkg::ROUND_K[ctl.rnd] + wt;
    t2 = e0 + mj;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::INIT_HASH[i];
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
    end
    if (ctl.load) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end else if (ctl.round) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      // sliding window: w[0] is W[t-16], w[15] is W[t-1]
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= wt;
    end
  end

  assign rd_word = chain[rd_idx];

endmodule

@@ hdl/sha256_message_digest_core.sv @@
// SHA-256 core top level: byte buffer, padding sequencer, digest output.
// Depends on sha256_pkg and sha256_round.
// One byte per transaction is taken. The 64th byte of a block starts a
// compression on the single shared round unit. The working variables load in
// the accepting cycle, then the round states and the fold state follow.
// in_ready is low during those states. A padding compression also needs a load
// state (ST_PAD) before its rounds. An end item adds one or two padding
// compressions, and in_ready stays low through them. If the item also
// completed a block, its own compression comes first and one padding
// compression follows. The eight digest words then leave one per cycle while
// out_ready is high, and in_ready stays low until the last word is taken.
module sha256_message_digest_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sha256_pkg::state_t state, state_next;
  sha256_pkg::rnd_ctl_t ctl;

  logic [31:0] blk [16];    // block store as big-endian words
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [5:0]  rnd;
  logic        ending;       // padding pending for this message
  logic        len_done;     // length block already compressed
  logic [2:0]  oidx;
  logic [31:0] rd_word;
  logic        acc;
  logic        full_byte;
  logic        marker_owed;  // marker still owed: true on the first padding block only

  assign acc       = in_valid && in_ready;
  assign full_byte = acc && byte_present && (fill == 6'd63);

  function automatic logic first_pad_ok();
    first_pad_ok = marker_owed;
  endfunction

  // length goes in when this pad block is the final one
  function automatic logic len_place();
    len_place = !marker_owed || (fill < 6'd56);
  endfunction

  sha256_round u_round (
    .clk(clk), .ctl(ctl), .w_in(blk[rnd[3:0]]), .rst(rst),
    .rd_idx(oidx), .rd_word(rd_word)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sha256_pkg::ST_IDLE:
        if (acc && (full_byte || end_of_message))
          state_next = full_byte ? sha256_pkg::ST_ROUND : sha256_pkg::ST_PAD;
      sha256_pkg::ST_PAD:   state_next = sha256_pkg::ST_ROUND;
      sha256_pkg::ST_ROUND: if (rnd == 6'd63) state_next = sha256_pkg::ST_FOLD;
      sha256_pkg::ST_FOLD:
        if (!ending)        state_next = sha256_pkg::ST_IDLE;
        else if (len_done)  state_next = sha256_pkg::ST_OUT;
        else                state_next = sha256_pkg::ST_PAD;
      sha256_pkg::ST_OUT:
        if (out_ready && oidx == 3'd7) state_next = sha256_pkg::ST_IDLE;
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state == sha256_pkg::ST_IDLE);
    out_valid = (state == sha256_pkg::ST_OUT);
    ctl       = '0;
    ctl.rnd   = rnd;
    unique case (state)
      sha256_pkg::ST_IDLE:  ctl.load  = 1'b1;
      sha256_pkg::ST_PAD:   ctl.load  = 1'b1;
      sha256_pkg::ST_ROUND: ctl.round = 1'b1;
      sha256_pkg::ST_FOLD:  ctl.fold  = 1'b1;
      sha256_pkg::ST_OUT:   ctl.init  = out_ready && (oidx == 3'd7);
      default: ctl = '0;
    endcase
  end

  assign digest_word = rd_word;
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sha256_pkg::ST_IDLE;
      fill     <= '0;
      bit_len  <= '0;
      rnd      <= '0;
      ending   <= 1'b0;
      len_done <= 1'b0;
      oidx     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        sha256_pkg::ST_IDLE: begin
          rnd <= '0;
          if (acc) begin
            if (byte_present) begin
              fill    <= fill + 6'd1;
              bit_len <= bit_len + 64'd8;
            end
            ending <= end_of_message;
            // 0x80 marker lands now unless the block just filled
            if (end_of_message && !full_byte) len_done <= (fill + 6'(byte_present)) < 6'd56;
            else len_done <= 1'b0;
          end
        end
        sha256_pkg::ST_PAD: rnd <= '0;
        sha256_pkg::ST_ROUND: rnd <= rnd + 6'd1;
        sha256_pkg::ST_FOLD: begin
          fill <= '0;
          if (ending && !len_done) len_done <= 1'b1;
        end
        sha256_pkg::ST_OUT:
          if (out_ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              fill <= '0; bit_len <= '0; ending <= 1'b0; len_done <= 1'b0;
            end
          end
        default: ;
      endcase
    end
  end

  // block store writes: incoming bytes, padding while in PAD
  always_ff @(posedge clk) begin
    if (state == sha256_pkg::ST_IDLE && acc && byte_present)
      blk[fill[5:2]][8 * (3 - fill[1:0]) +: 8] <= data_byte;
    if (state == sha256_pkg::ST_PAD) begin
      // fill is position of first pad byte; 0x80 placed only while the marker is still owed
      for (int i = 0; i < 16; i++)
        for (int b = 0; b < 4; b++)
          if (6'(4 * i + b) > fill || (6'(4 * i + b) == fill && fill == 6'd0 && !first_pad_ok()))
            blk[i][8 * (3 - b) +: 8] <= 8'h00;
          else if (6'(4 * i + b) == fill && first_pad_ok())
            blk[i][8 * (3 - b) +: 8] <= 8'h80;
      if (len_place()) begin
        blk[14] <= bit_len[63:32];
        blk[15] <= bit_len[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) marker_owed <= 1'b0;
    else if (state == sha256_pkg::ST_IDLE && acc) marker_owed <= end_of_message;
    else if (state == sha256_pkg::ST_PAD) marker_owed <= 1'b0;
  end

  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    (state == sha256_pkg::ST_ROUND) |-> !in_ready)
    else $error("ready during compression");
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while digest pending");
  a_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> (state == sha256_pkg::ST_IDLE))
    else $error("sequencer did not return after last word");

endmodule

@@ bench/sha256_digest_checker.sv @@
// Digest checker: watches the byte and digest channels, hashes accepted bytes
// and compares each digest word with the expected one. Depends on sha256_pkg.
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          fail_count,
  output int          words_pending
);

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int unsigned fill;
  logic [63:0] bit_len;
  digest_word_t digest_fifo [$];

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic absorb(logic [7:0] b, logic has_byte, logic eom);
    int unsigned p;
    if (has_byte) begin
      msg_block[fill] = b;
      fill++;
      bit_len += 64'd8;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    end
    if (!eom) return;
    p = fill;
    msg_block[p] = 8'h80;
    p++;
    if (p > 56) begin
      while (p < 64) begin
        msg_block[p] = 8'h00;
        p++;
      end
      compress_block();
      p = 0;
    end
    while (p < 56) begin
      msg_block[p] = 8'h00;
      p++;
    end
    for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++)
      digest_fifo.push_back('{hash_state[i], 3'(i), i == 7});
    hash_state = sha256_pkg::INIT_HASH;
    fill = 0;
    bit_len = '0;
  endtask

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst) begin
      hash_state = sha256_pkg::INIT_HASH;
      fill = 0;
      bit_len = '0;
      digest_fifo.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_fifo.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d last %b", $time,
                   digest_word, word_index, last_word);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = digest_fifo.pop_front();
          if (digest_word !== exp_w.word || word_index !== exp_w.idx ||
              last_word !== exp_w.last) begin
            $display("%0t: digest mismatch exp %h/%0d/%b got %h/%0d/%b", $time,
                     exp_w.word, exp_w.idx, exp_w.last, digest_word, word_index, last_word);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) absorb(data_byte, byte_present, end_of_message);
    end
    words_pending = digest_fifo.size();
  end
endmodule

@@ bench/sha256_message_digest_core_tb.sv @@
// Testbench top: drives message bytes into the SHA-256 core with random idling
// and gives the verdict. Depends on sha256_pkg, the core and sha256_digest_checker.
module sha256_message_digest_core_tb;
  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [7:0]  data_byte;
  logic        byte_present, end_of_message;
  logic        out_valid, out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count, words_pending;
  int          send_idle_pct, recv_idle_pct;
  int          quiet_cycles;
  bit          stim_done;

  localparam int WATCHDOG_LIMIT = 20000;

  sha256_message_digest_core dut (.*);
  sha256_digest_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one transaction; holds valid until accepted, idles at random beforehand
  task automatic send_item(logic [7:0] b, logic has_byte, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    byte_present <= has_byte;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_message(int len, logic empty_end);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, !empty_end && i == len - 1);
    if (empty_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(0, 10);
    if (r < 90) return $urandom_range(52, 66);
    return $urandom_range(110, 130);
  endfunction

  initial begin
    int ph_sent;
    int len;
    stim_done = 0;
    rst = 1; in_valid = 0; data_byte = 0; byte_present = 0; end_of_message = 0;
    send_idle_pct = 14; recv_idle_pct = 85;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, ignored items, padding boundaries
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    send_message(63, 1'b1);
    send_message(64, 1'b0);

    // hold off until the digests so far have all drained
    in_valid <= 1'b0;
    @(posedge clk);
    wait (words_pending == 0);
    @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 85 : 0;
      recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 14 : 0;
      ph_sent = 0;
      while (ph_sent < 35) begin
        if ($urandom_range(9) == 0) begin
          send_item(8'($urandom), 1'b0, 1'b0);
          ph_sent++;
        end else begin
          len = pick_len();
          send_message(len, $urandom_range(3) == 0);
          ph_sent += len + 1;
        end
      end
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

@@ files.f @@
hdl/sha256_pkg.sv
hdl/sha256_round.sv
hdl/sha256_message_digest_core.sv
bench/sha256_digest_checker.sv
bench/sha256_message_digest_core_tb.sv
